// ===== hw/rtl/ielp_pkg.sv =====
// I/O event latency pairing: shared types, constants and the per-kind rule table.
// No dependencies; used by io_event_latency_pairing_unit.
`default_nettype none

package ielp_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned KIND_W          = 6;
  localparam int unsigned TAG_W           = 32;
  localparam int unsigned TS_W            = 64;
  localparam int unsigned NUM_W           = 32;

  localparam logic [KIND_W-1:0] KIND_COUNT = 6'd41;
  localparam logic [KIND_W-1:0] NO_KIND    = 6'd63;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [TAG_W-1:0]  tag;
    logic [TS_W-1:0]   timestamp;
  } in_item_t;

  typedef struct packed {
    logic              is_match;
    logic [TS_W-1:0]   delta_ticks;
    logic [NUM_W-1:0]  matched_number;
    logic [KIND_W-1:0] matched_kind;
    logic [NUM_W-1:0]  own_number;
    logic              stored;
    logic              table_full;
    logic              unknown_kind;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [KIND_W-1:0] kind;
    logic [TS_W-1:0]   stamp;
    logic [NUM_W-1:0]  rec_num;
  } entry_t;

  typedef struct packed {
    logic              store;
    logic              erase;
    logic [KIND_W-1:0] p1;
    logic [KIND_W-1:0] p2;
  } rule_t;

  // store / erase-on-match / partner kinds for each dense kind code
  function automatic rule_t kind_rule(input logic [KIND_W-1:0] kind);
    rule_t r;
    unique case (kind)
      6'd0:  r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd1:  r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd2:  r = '{1'b0, 1'b1, 6'd0,  6'd1};
      6'd3:  r = '{1'b0, 1'b1, 6'd0,  6'd1};
      6'd4:  r = '{1'b0, 1'b1, 6'd0,  6'd1};
      6'd5:  r = '{1'b0, 1'b1, 6'd0,  6'd1};
      6'd6:  r = '{1'b0, 1'b0, 6'd0,  6'd1};
      6'd7:  r = '{1'b0, 1'b1, 6'd6,  NO_KIND};
      6'd8:  r = '{1'b0, 1'b1, 6'd0,  6'd1};
      6'd9:  r = '{1'b1, 1'b0, 6'd0,  6'd1};
      6'd10: r = '{1'b0, 1'b1, 6'd9,  NO_KIND};
      6'd11: r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd12: r = '{1'b0, 1'b1, 6'd11, NO_KIND};
      6'd13: r = '{1'b1, 1'b0, 6'd31, NO_KIND};
      6'd14: r = '{1'b0, 1'b1, 6'd13, NO_KIND};
      6'd15: r = '{1'b1, 1'b0, 6'd31, NO_KIND};
      6'd16: r = '{1'b0, 1'b1, 6'd15, NO_KIND};
      6'd17: r = '{1'b1, 1'b0, 6'd31, NO_KIND};
      6'd18: r = '{1'b0, 1'b0, 6'd17, NO_KIND};
      6'd19: r = '{1'b0, 1'b1, 6'd17, NO_KIND};
      6'd20: r = '{1'b0, 1'b0, 6'd31, NO_KIND};
      6'd21: r = '{1'b1, 1'b0, 6'd31, NO_KIND};
      6'd22: r = '{1'b0, 1'b1, 6'd21, NO_KIND};
      6'd23: r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd24: r = '{1'b0, 1'b1, 6'd23, NO_KIND};
      6'd25: r = '{1'b1, 1'b0, 6'd31, NO_KIND};
      6'd26: r = '{1'b0, 1'b1, 6'd25, NO_KIND};
      6'd27: r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd28: r = '{1'b0, 1'b1, 6'd27, NO_KIND};
      6'd29: r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd30: r = '{1'b0, 1'b1, 6'd29, NO_KIND};
      6'd31: r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd32: r = '{1'b0, 1'b0, 6'd31, NO_KIND};
      6'd33: r = '{1'b0, 1'b1, 6'd31, NO_KIND};
      6'd34: r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd35: r = '{1'b0, 1'b1, 6'd34, NO_KIND};
      6'd36: r = '{1'b0, 1'b1, 6'd34, NO_KIND};
      6'd37: r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd38: r = '{1'b1, 1'b0, NO_KIND, NO_KIND};
      6'd39: r = '{1'b0, 1'b1, 6'd38, NO_KIND};
      6'd40: r = '{1'b0, 1'b1, 6'd37, NO_KIND};
      default: r = '{1'b0, 1'b0, NO_KIND, NO_KIND};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/io_event_latency_pairing_unit.sv =====
// Flow: an event is taken in S_IDLE, then its partner scan walks the n live
// entries (at most TABLE_DEPTH) at one entry per cycle through the table's single
// read port, holding while a match waits on the result side, then the summary goes
// out. Kinds without partners, or an event that finds the table empty, skip the scan.
// Reset (synchronous, rst_n low): table empties, record number returns to one.
// Table contents are not cleared; a fill count marks the live prefix. Needs ielp_pkg.
`default_nettype none

module io_event_latency_pairing_unit #(
  parameter int unsigned TABLE_DEPTH = ielp_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ielp_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ielp_pkg::out_item_t       out_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SUM
  } state_t;

  state_t                           state_r, state_nxt;
  logic [ielp_pkg::TAG_W-1:0]       tag_r, tag_nxt;
  logic [ielp_pkg::TS_W-1:0]        ts_r, ts_nxt;
  logic [ielp_pkg::NUM_W-1:0]       own_r, own_nxt;
  logic [ielp_pkg::NUM_W-1:0]       cnt_r, cnt_nxt;
  logic                             stored_r, stored_nxt;
  logic                             full_r, full_nxt;
  logic                             unknown_r, unknown_nxt;
  logic                             erase_r, erase_nxt;
  logic [ielp_pkg::KIND_W-1:0]      p1_r, p1_nxt;
  logic [ielp_pkg::KIND_W-1:0]      p2_r, p2_nxt;
  logic [CNT_W-1:0]                 n_r, n_nxt;
  logic [CNT_W-1:0]                 scan_n_r, scan_n_nxt;
  logic [CNT_W-1:0]                 i_r, i_nxt;
  logic [CNT_W-1:0]                 w_r, w_nxt;
  logic                             out_valid_r, out_valid_nxt;
  ielp_pkg::out_item_t              out_r, out_nxt;

  // entry table
  ielp_pkg::entry_t                 mem [TABLE_DEPTH];
  ielp_pkg::entry_t                 rd_q;
  ielp_pkg::entry_t                 mem_wd;
  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_wa;
  logic [IDX_W-1:0]                 rd_addr;

  ielp_pkg::rule_t                  rule;
  logic                             slot_free;
  logic                             hit;
  logic                             keep;
  logic [CNT_W-1:0]                 i_inc;
  logic [CNT_W-1:0]                 w_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign slot_free = !out_valid_r || out_ready;
  assign rule      = ielp_pkg::kind_rule(in_data.event_kind);
  assign hit       = (rd_q.tag == tag_r) && ((rd_q.kind == p1_r) || (rd_q.kind == p2_r));
  assign keep      = !(hit && erase_r);
  assign i_inc     = i_r + 1'b1;
  assign w_inc     = w_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    tag_nxt       = tag_r;
    ts_nxt        = ts_r;
    own_nxt       = own_r;
    cnt_nxt       = cnt_r;
    stored_nxt    = stored_r;
    full_nxt      = full_r;
    unknown_nxt   = unknown_r;
    erase_nxt     = erase_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    n_nxt         = n_r;
    scan_n_nxt    = scan_n_r;
    i_nxt         = i_r;
    w_nxt         = w_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = w_r[IDX_W-1:0];
    mem_wd        = rd_q;
    rd_addr       = i_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          tag_nxt    = in_data.tag;
          ts_nxt     = in_data.timestamp;
          erase_nxt  = rule.erase;
          p1_nxt     = rule.p1;
          p2_nxt     = rule.p2;
          scan_n_nxt = n_r;
          i_nxt      = '0;
          w_nxt      = '0;
          if (in_data.event_kind >= ielp_pkg::KIND_COUNT) begin
            unknown_nxt = 1'b1;
            own_nxt     = '0;
            stored_nxt  = 1'b0;
            full_nxt    = 1'b0;
            state_nxt   = S_SUM;
          end else begin
            unknown_nxt = 1'b0;
            own_nxt     = cnt_r;
            cnt_nxt     = cnt_r + 1'b1;
            stored_nxt  = rule.store && (n_r < DEPTH_C);
            full_nxt    = rule.store && !(n_r < DEPTH_C);
            // append now; the new entry sits past the scanned prefix and is
            // never its own partner
            if (rule.store && (n_r < DEPTH_C)) begin
              mem_we = 1'b1;
              mem_wa = n_r[IDX_W-1:0];
              mem_wd = '{tag: in_data.tag, kind: in_data.event_kind,
                         stamp: in_data.timestamp, rec_num: cnt_r};
              n_nxt  = n_r + 1'b1;
            end
            if ((rule.p1 != ielp_pkg::NO_KIND) && (n_r != '0)) begin
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_SUM;
            end
          end
        end
      end

      S_SCAN: begin
        // rd_q holds entry i; survivors are compacted down to w
        if (hit && !slot_free) begin
          rd_addr = i_r[IDX_W-1:0];
        end else begin
          if (hit) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{is_match: 1'b1, delta_ticks: ts_r - rd_q.stamp,
                        matched_number: rd_q.rec_num, matched_kind: rd_q.kind,
                        own_number: own_r, stored: stored_r, table_full: full_r,
                        unknown_kind: 1'b0, last: 1'b0};
          end
          if (keep) begin
            mem_we = 1'b1;
            mem_wa = w_r[IDX_W-1:0];
            mem_wd = rd_q;
            w_nxt  = w_inc;
          end
          i_nxt   = i_inc;
          rd_addr = i_inc[IDX_W-1:0];
          if (i_inc == scan_n_r) begin
            // erasing kinds never store, so the compacted prefix is the table
            if (erase_r) begin
              n_nxt = keep ? w_inc : w_r;
            end
            state_nxt = S_SUM;
          end
        end
      end

      S_SUM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{is_match: 1'b0, delta_ticks: '0, matched_number: '0,
                      matched_kind: '0, own_number: own_r, stored: stored_r,
                      table_full: full_r, unknown_kind: unknown_r, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tag_r     <= tag_nxt;
    ts_r      <= ts_nxt;
    own_r     <= own_nxt;
    stored_r  <= stored_nxt;
    full_r    <= full_nxt;
    unknown_r <= unknown_nxt;
    erase_r   <= erase_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    scan_n_r  <= scan_n_nxt;
    i_r       <= i_nxt;
    w_r       <= w_nxt;
    out_r     <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= ielp_pkg::NUM_W'(1);
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= DEPTH_C)
    else $error("fill count beyond table depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (n_r <= $past(n_r) + 1'b1))
    else $error("fill count grew by more than one");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((w_r <= i_r) && (i_r < scan_n_r)))
    else $error("compaction index passed scan index");

  a_match_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_match) |-> (!out_r.last && !out_r.unknown_kind))
    else $error("match transfer flagged as summary");
`endif

endmodule

`default_nettype wire
